// File: sv/dta_pkg.sv
// ---------------------------------------------------------------------------
// dta_pkg
// Shared types and constants for the detection/track association.
// ---------------------------------------------------------------------------
package dta_pkg;

    localparam int MaxTracks = 32;
    localparam int IdxW      = $clog2(MaxTracks);
    localparam int CntW      = $clog2(MaxTracks + 1);
    localparam int AddrW     = IdxW + 1;
    localparam int DepthW    = 2 * MaxTracks;
    // box word: left, top, right, bottom (14 bits each) and identifier
    localparam int EntryW    = 4 * 14 + 16;

    localparam logic [1:0] CfgMinSize = 2'd0;
    localparam logic [1:0] CfgAspect  = 2'd1;
    localparam logic [1:0] CfgOverlap = 2'd2;

    localparam logic [11:0] DefaultMinSize = 12'd20;

    // classified item travelling from front to back
    typedef struct packed {
        logic              eof;
        logic              valid_box;
        logic signed [13:0] left;
        logic signed [13:0] top;
        logic signed [13:0] right;
        logic signed [13:0] bottom;
    } dta_cmd_t;

    typedef struct packed {
        logic               accepted;
        logic               matched;
        logic signed [15:0] track_id;
        logic signed [13:0] left;
        logic signed [13:0] top;
        logic signed [13:0] right;
        logic signed [13:0] bottom;
        logic [5:0]         fill_count;
        logic [31:0]        frame_number;
        logic               frame_done;
    } dta_res_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_SCAN, ST_RDBEST, ST_AREA, ST_MUL, ST_CMP,
        ST_RDTAIL, ST_MOVE, ST_WRITE, ST_OUT
    } dta_state_t;

endpackage

// File: sv/dta_ram.sv
// ---------------------------------------------------------------------------
// dta_ram
// Generic single-write, single-read memory with registered read data.
// ---------------------------------------------------------------------------
module dta_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/dta_front.sv
// ---------------------------------------------------------------------------
// dta_front
// Accepts items, checks box size and shape, forms corners, queues commands.
// ---------------------------------------------------------------------------
module dta_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_eof,
    input  logic signed [12:0]   in_x,
    input  logic signed [12:0]   in_y,
    input  logic [11:0]          in_w,
    input  logic [11:0]          in_h,
    input  logic [11:0]          min_size,
    input  logic [10:0]          aspect_limit,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output dta_pkg::dta_cmd_t    cmd
);
    import dta_pkg::*;

    // two-entry queue towards the back part
    dta_cmd_t        q_reg [2];
    logic [1:0]      q_cnt_reg, q_cnt_next;
    logic            q_rd_reg, q_rd_next;
    logic [CntW-1:0] seen_reg, seen_next;
    dta_cmd_t        new_cmd;
    logic [11:0]     minsz, diff, longer;
    logic [22:0]     lhs, rhs;
    logic            take, give;

    assign in_ready  = (q_cnt_reg != 2'd2);
    assign take      = in_valid && in_ready;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign give      = cmd_valid && cmd_ready;
    assign cmd       = q_reg[q_rd_reg];

    // classification
    always_comb begin
        minsz  = (min_size == 12'd0) ? DefaultMinSize : min_size;
        diff   = (in_w > in_h) ? in_w - in_h : in_h - in_w;
        longer = (in_w > in_h) ? in_w : in_h;
        lhs    = {1'b0, diff, 10'd0};
        rhs    = 23'(aspect_limit) * 23'(longer);
        new_cmd.eof       = in_eof;
        new_cmd.valid_box = !in_eof && (seen_reg < CntW'(MaxTracks)) &&
                            (in_w >= minsz) && (in_h >= minsz) && (lhs < rhs);
        new_cmd.left   = 14'(in_x);
        new_cmd.top    = 14'(in_y);
        new_cmd.right  = 14'(in_x) + 14'(in_w) - 14'sd1;
        new_cmd.bottom = 14'(in_y) + 14'(in_h) - 14'sd1;
        if (in_eof) begin
            seen_next = '0;
        end else if (seen_reg < CntW'(MaxTracks)) begin
            seen_next = seen_reg + 1'b1;
        end else begin
            seen_next = seen_reg;
        end
        q_cnt_next = q_cnt_reg + 2'(take) - 2'(give);
        q_rd_next  = q_rd_reg ^ give;
    end

    // queue payload
    always_ff @(posedge aclk) begin
        if (take) begin
            q_reg[q_rd_reg ^ q_cnt_reg[0]] <= new_cmd;
        end
    end

    // queue control and detection count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= '0;
            q_rd_reg  <= 1'b0;
            seen_reg  <= '0;
        end else begin
            q_cnt_reg <= q_cnt_next;
            q_rd_reg  <= q_rd_next;
            if (take) begin
                seen_reg <= seen_next;
            end
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg != 2'd3) else $error("queue count out of range");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg == 2'd2 |-> !in_ready) else $error("full queue accepts");
    a_seen_max: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg <= CntW'(MaxTracks)) else $error("detection count overflow");
endmodule

// File: sv/dta_back.sv
// ---------------------------------------------------------------------------
// dta_back
// Scans previous tracks, decides matches, updates the track tables.
// ---------------------------------------------------------------------------
module dta_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  dta_pkg::dta_cmd_t    cmd,
    input  logic [10:0]          overlap_thr,
    output logic                 res_valid,
    input  logic                 res_ready,
    output dta_pkg::dta_res_t    res
);
    import dta_pkg::*;

    dta_state_t       state_reg, state_next;
    dta_cmd_t         cur_reg, cur_next;
    dta_res_t         res_reg, res_next;
    logic [CntW-1:0]  cnt_reg [2];
    logic [CntW-1:0]  cnt_next [2];
    logic             bank_reg, bank_next;
    logic [15:0]      nid_reg, nid_next;
    logic [31:0]      frame_reg, frame_next;
    logic [CntW-1:0]  idx_reg, idx_next;
    logic [IdxW-1:0]  slot_reg, slot_next;
    logic [29:0]      best_reg, best_next;
    logic [24:0]      area_a_reg, area_a_next, area_b_reg, area_b_next;
    logic [40:0]      lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic [15:0]      mid_reg, mid_next;
    logic             rvalid_reg, rvalid_next;

    logic             we;
    logic [AddrW-1:0] waddr, raddr;
    logic [EntryW-1:0] wdata, rdata;

    logic signed [13:0] e_l, e_t, e_r, e_b;
    logic signed [15:0] dx, dy;
    logic [29:0]        sq_dist;
    logic [12:0]        bw, bh;
    logic [26:0]        sum_ab;
    logic [30:0]        sum_all;
    logic signed [30:0] diffs;
    logic               fill;

    dta_ram #(.Width(EntryW), .Depth(DepthW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign {e_l, e_t, e_r, e_b} = rdata[EntryW-1:16];
    assign fill      = !bank_reg;
    assign cmd_ready = (state_reg == ST_IDLE) && !rvalid_reg;
    assign res_valid = rvalid_reg;
    assign res       = res_reg;

    // sequencer
    always_comb begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        res_next    = res_reg;
        cnt_next    = cnt_reg;
        bank_next   = bank_reg;
        nid_next    = nid_reg;
        frame_next  = frame_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        best_next   = best_reg;
        area_a_next = area_a_reg;
        area_b_next = area_b_reg;
        lhs_next    = lhs_reg;
        rhs_next    = rhs_reg;
        mid_next    = mid_reg;
        rvalid_next = rvalid_reg && !res_ready;
        we    = 1'b0;
        waddr = {fill, idx_reg[IdxW-1:0]};
        wdata = '0;
        raddr = {bank_reg, idx_reg[IdxW-1:0]};
        dx    = 16'(cur_reg.left) + 16'(cur_reg.right) - 16'(e_l) - 16'(e_r);
        dy    = 16'(cur_reg.top) + 16'(cur_reg.bottom) - 16'(e_t) - 16'(e_b);
        sq_dist = $unsigned(30'(dx * dx)) + $unsigned(30'(dy * dy));
        bw    = 13'(e_r - e_l + 14'sd1);
        bh    = 13'(e_b - e_t + 14'sd1);
        sum_ab  = 27'(area_a_reg) + 27'(area_b_reg);
        sum_all = 31'(sum_ab) + 31'(best_reg);
        diffs   = $signed({4'b0, sum_ab}) - $signed({1'b0, best_reg});
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && !rvalid_reg) begin
                    cur_next = cmd;
                    idx_next = '0;
                    res_next = '0;
                    res_next.frame_number = frame_reg;
                    if (cmd.eof) begin
                        // swap banks, the discarded table reads as empty
                        bank_next  = fill;
                        cnt_next[bank_reg] = '0;
                        frame_next = frame_reg + 32'd1;
                        res_next.frame_number  = frame_reg + 32'd1;
                        res_next.frame_done    = 1'b1;
                        state_next = ST_OUT;
                    end else if (cmd.valid_box && cnt_reg[fill] < CntW'(MaxTracks)) begin
                        state_next = ST_RD;
                    end else begin
                        res_next.fill_count = 6'(cnt_reg[fill]);
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RD: begin
                // first read issued this cycle
                if (cnt_reg[bank_reg] == '0) begin
                    state_next = ST_WRITE;
                    mid_next   = '0;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rdata holds entry idx_reg-1
                if (idx_reg == CntW'(1) || sq_dist < best_reg) begin
                    best_next = sq_dist;
                    slot_next = IdxW'(idx_reg - 1'b1);
                end
                if (idx_reg == cnt_reg[bank_reg]) begin
                    state_next = ST_RDBEST;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RDBEST: begin
                raddr = {bank_reg, slot_reg};
                area_a_next = 25'((13'(cur_reg.right - cur_reg.left + 14'sd1))
                                  * (13'(cur_reg.bottom - cur_reg.top + 14'sd1)));
                state_next = ST_AREA;
            end
            ST_AREA: begin
                raddr = {bank_reg, slot_reg};
                area_b_next = 25'(bw * bh);
                mid_next    = rdata[15:0];
                state_next  = ST_MUL;
            end
            ST_MUL: begin
                // negative left side never passes, so it is held at zero
                lhs_next = (diffs < 0) ? '0 : 41'({diffs[29:0], 10'd0});
                rhs_next = 41'(sum_all * overlap_thr);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (diffs >= 0 && lhs_reg >= rhs_reg) begin
                    res_next.matched  = 1'b1;
                    res_next.track_id = mid_reg;
                    idx_next = cnt_reg[bank_reg] - 1'b1;
                    state_next = ST_RDTAIL;
                end else begin
                    idx_next   = '0;
                    state_next = ST_WRITE;
                end
            end
            ST_RDTAIL: begin
                state_next = ST_MOVE;
            end
            ST_MOVE: begin
                we    = (idx_reg[IdxW-1:0] != slot_reg);
                waddr = {bank_reg, slot_reg};
                wdata = rdata;
                cnt_next[bank_reg] = idx_reg;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (!res_reg.matched) begin
                    nid_next = nid_reg + 16'd1;
                    res_next.track_id = nid_reg + 16'd1;
                end
                we    = 1'b1;
                waddr = {fill, cnt_reg[fill][IdxW-1:0]};
                wdata = {cur_reg.left, cur_reg.top, cur_reg.right, cur_reg.bottom,
                         res_reg.matched ? res_reg.track_id : nid_reg + 16'd1};
                cnt_next[fill] = cnt_reg[fill] + 1'b1;
                res_next.accepted = 1'b1;
                res_next.left   = cur_reg.left;
                res_next.top    = cur_reg.top;
                res_next.right  = cur_reg.right;
                res_next.bottom = cur_reg.bottom;
                res_next.fill_count = 6'(cnt_reg[fill] + 1'b1);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                rvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // data path registers
    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        res_reg    <= res_next;
        idx_reg    <= idx_next;
        slot_reg   <= slot_next;
        best_reg   <= best_next;
        area_a_reg <= area_a_next;
        area_b_reg <= area_b_next;
        lhs_reg    <= lhs_next;
        rhs_reg    <= rhs_next;
        mid_reg    <= mid_next;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            bank_reg   <= 1'b0;
            nid_reg    <= '0;
            frame_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            bank_reg   <= bank_next;
            nid_reg    <= nid_next;
            frame_reg  <= frame_next;
            rvalid_reg <= rvalid_next;
        end
    end

    a_cnt0: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= CntW'(MaxTracks)) else $error("bank 0 count overflow");
    a_cnt1: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[1] <= CntW'(MaxTracks)) else $error("bank 1 count overflow");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !cmd_ready) else $error("ready while busy");
    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg && res_reg.frame_done |-> !res_reg.accepted)
        else $error("frame result marked accepted");
endmodule

// File: sv/detection_track_association.sv
// ---------------------------------------------------------------------------
// detection_track_association
// Greedy nearest-neighbour association of detection boxes with tracks.
// ---------------------------------------------------------------------------
// channel   direction  handshake            payload
// s_axis    in         s_tvalid/s_tready    box, tuser = end of frame
// m_axis    out        m_tvalid/m_tready    association result
// cfg       in         cfg_valid/cfg_ready  register index and value
//
// A box holds the back part while the scan reads the previous-frame tracks,
// one stored track per cycle from one RAM port; a box that inherits a track
// also moves the last stored track into the matched slot. End of frame and
// rejected boxes skip the scan.
// Reset is synchronous and clears counts and control; RAM is not cleared.
// A two-entry queue lets the input run ahead while the scan stalls.
module detection_track_association (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // box_x, box_y, box_width, box_height
    input  logic        s_tuser,   // end of frame
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [111:0] m_tdata,  // track_id, left, top, right, bottom,
                                   // fill_count, frame_number
    output logic [2:0]  m_tuser,   // accepted, matched, frame_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import dta_pkg::*;

    logic [11:0] min_size_reg;
    logic [10:0] aspect_reg, overlap_reg;
    logic        cmd_valid, cmd_ready;
    dta_cmd_t    cmd;
    dta_res_t    res;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_size_reg <= DefaultMinSize;
            aspect_reg   <= 11'd409;
            overlap_reg  <= 11'd645;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CfgMinSize: min_size_reg <= cfg_data;
                CfgAspect:  aspect_reg   <= cfg_data[10:0];
                CfgOverlap: overlap_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    dta_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_eof(s_tuser),
        .in_x(s_tdata[12:0]), .in_y(s_tdata[25:13]),
        .in_w(s_tdata[37:26]), .in_h(s_tdata[49:38]),
        .min_size(min_size_reg), .aspect_limit(aspect_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    dta_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .overlap_thr(overlap_reg),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {2'd0, res.frame_number, res.fill_count, res.bottom,
                      res.right, res.top, res.left, res.track_id};
    assign m_tuser = {res.frame_done, res.matched, res.accepted};
endmodule
